FILE: rtl/core/fms_pkg.sv
package fms_pkg;

	// Receiver window in which both counts must lie before the drive is enabled.
	localparam logic [15:0] VALID_LOW   = 16'd1600;
	localparam logic [15:0] VALID_HIGH  = 16'd4400;
	// Ticks without both channels reporting before the fail counts are used.
	localparam logic [8:0]  WATCH_LIMIT = 9'd500;
	// Ticks per motor ramp step.
	localparam logic [4:0]  RAMP_DIVIDE = 5'd20;
	// One half in Q.12, added before the command is truncated.
	localparam int          ROUND_HALF  = 2048;
	localparam logic [7:0]  CMD_MAX     = 8'd255;

	typedef enum logic [2:0] {
		REG_FOLD_THRESHOLD  = 3'd0,
		REG_MOTOR_THRESHOLD = 3'd1,
		REG_SERVO1_MIN      = 3'd2,
		REG_SERVO1_MAX      = 3'd3,
		REG_SERVO2_MIN      = 3'd4,
		REG_MOTOR_GAIN      = 3'd5,
		REG_MOTOR_OFFSET    = 3'd6,
		REG_FAIL_COUNT      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        fold_threshold;
		logic [15:0]        motor_threshold;
		logic [15:0]        servo1_min;
		logic [15:0]        servo1_max;
		logic [7:0]         servo2_min;
		logic signed [15:0] motor_gain;
		logic signed [23:0] motor_offset;
		logic [15:0]        fail_count;
	} cfg_t;

	typedef struct packed {
		logic        ch1_update;
		logic [15:0] ch1_count;
		logic        ch2_update;
		logic [15:0] ch2_count;
	} item_t;

	// Handed from the front end to the sequencer through the product register.
	typedef struct packed {
		logic [15:0]        held_ch1;
		logic signed [32:0] product;
		logic               enabled;
		logic               lost;
	} mid_t;

	typedef struct packed {
		logic [15:0] fold_pulse;
		logic [7:0]  motor_pulse;
		logic        drive_enable;
		logic [2:0]  sequence_mode;
		logic        link_lost;
		logic [7:0]  motor_command;
	} res_t;

	typedef enum logic [6:0] {
		MODE_OFF       = 7'b0000001,
		MODE_FOLD_OUT  = 7'b0000010,
		MODE_OUT       = 7'b0000100,
		MODE_RAMP_UP   = 7'b0001000,
		MODE_ON        = 7'b0010000,
		MODE_RAMP_DOWN = 7'b0100000,
		MODE_FOLD_IN   = 7'b1000000
	} mode_t;

	localparam logic [2:0] CODE_OFF       = 3'd0;
	localparam logic [2:0] CODE_FOLD_OUT  = 3'd1;
	localparam logic [2:0] CODE_OUT       = 3'd2;
	localparam logic [2:0] CODE_RAMP_UP   = 3'd3;
	localparam logic [2:0] CODE_ON        = 3'd4;
	localparam logic [2:0] CODE_RAMP_DOWN = 3'd5;
	localparam logic [2:0] CODE_FOLD_IN   = 3'd7;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		case (m)
			MODE_OFF:       c = CODE_OFF;
			MODE_FOLD_OUT:  c = CODE_FOLD_OUT;
			MODE_OUT:       c = CODE_OUT;
			MODE_RAMP_UP:   c = CODE_RAMP_UP;
			MODE_ON:        c = CODE_ON;
			MODE_RAMP_DOWN: c = CODE_RAMP_DOWN;
			MODE_FOLD_IN:   c = CODE_FOLD_IN;
			default:        c = CODE_OFF;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/fms_if.sv
interface fms_tick_if;
	logic        valid;
	logic        ready;
	logic        ch1_update;
	logic [15:0] ch1_count;
	logic        ch2_update;
	logic [15:0] ch2_count;

	modport source (output valid, ch1_update, ch1_count, ch2_update, ch2_count, input ready);
	modport sink (input valid, ch1_update, ch1_count, ch2_update, ch2_count, output ready);
endinterface

interface fms_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] fold_pulse;
	logic [7:0]  motor_pulse;
	logic        drive_enable;
	logic [2:0]  sequence_mode;
	logic        link_lost;
	logic [7:0]  motor_command;

	modport source (output valid, fold_pulse, motor_pulse, drive_enable, sequence_mode,
		link_lost, motor_command, input ready);
	modport sink (input valid, fold_pulse, motor_pulse, drive_enable, sequence_mode,
		link_lost, motor_command, output ready);
endinterface

FILE: rtl/core/fold_motor_sequencer.sv
// Fold and motor sequencer. Each request on the tick channel is one control tick carrying
// two receiver pulse counts and their update flags; each tick yields exactly one result
// with the fold servo and motor PWM compare values, the sticky drive enable, the sequence
// mode, the watchdog flag and the filtered motor command. One request is accepted in every
// clock cycle when the result side keeps up, and each request passes through an input
// register, a register behind the single gain multiplier, and the result register.
// That multiplier, fed through the watchdog's choice of count, sets the clock period; the
// offset add, saturation, hysteresis and mode logic take the stage after it. Registers are
// written through the APB port at byte address 4 * index and must only be changed while no
// tick is in flight.
module fold_motor_sequencer
	import fms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	fms_tick_if.sink          tick,
	fms_result_if.source      result
);

	// Configuration registers. The APB write completes in the access cycle; pready is tied
	// high so every transfer finishes without wait states.
	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fold_threshold  <= 16'd3000;
			cfg_q.motor_threshold <= 16'd3600;
			cfg_q.servo1_min      <= 16'd2000;
			cfg_q.servo1_max      <= 16'd4000;
			cfg_q.servo2_min      <= 8'd16;
			cfg_q.motor_gain      <= '0;
			cfg_q.motor_offset    <= '0;
			cfg_q.fail_count      <= 16'd2000;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_FOLD_THRESHOLD:  cfg_q.fold_threshold  <= pwdata[15:0];
				REG_MOTOR_THRESHOLD: cfg_q.motor_threshold <= pwdata[15:0];
				REG_SERVO1_MIN:      cfg_q.servo1_min      <= pwdata[15:0];
				REG_SERVO1_MAX:      cfg_q.servo1_max      <= pwdata[15:0];
				REG_SERVO2_MIN:      cfg_q.servo2_min      <= pwdata[7:0];
				REG_MOTOR_GAIN:      cfg_q.motor_gain      <= $signed(pwdata[15:0]);
				REG_MOTOR_OFFSET:    cfg_q.motor_offset    <= $signed(pwdata[23:0]);
				REG_FAIL_COUNT:      cfg_q.fail_count      <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the raw register bits, zero extended to the bus width.
	always_comb begin
		case (reg_idx)
			REG_FOLD_THRESHOLD:  prdata = {16'd0, cfg_q.fold_threshold};
			REG_MOTOR_THRESHOLD: prdata = {16'd0, cfg_q.motor_threshold};
			REG_SERVO1_MIN:      prdata = {16'd0, cfg_q.servo1_min};
			REG_SERVO1_MAX:      prdata = {16'd0, cfg_q.servo1_max};
			REG_SERVO2_MIN:      prdata = {24'd0, cfg_q.servo2_min};
			REG_MOTOR_GAIN:      prdata = {16'd0, cfg_q.motor_gain};
			REG_MOTOR_OFFSET:    prdata = {8'd0, cfg_q.motor_offset};
			REG_FAIL_COUNT:      prdata = {16'd0, cfg_q.fail_count};
			default:             prdata = '0;
		endcase
	end

	// Pipeline flow control. Each stage may load when it is empty or when the stage behind
	// it is moving, so a bubble anywhere lets a new request in even while a finished result
	// waits at the output.
	logic  s1_v_q, s2_v_q, out_v_q;
	item_t s1_q;
	mid_t  s2_q;
	res_t  out_q;
	logic  out_free, s2_free, s1_free, s1_adv, s2_adv;
	item_t tick_item;
	mid_t  mid;
	res_t  res;

	assign out_free = !out_v_q || result.ready;
	assign s2_free  = !s2_v_q || out_free;
	assign s1_free  = !s1_v_q || s2_free;
	assign s1_adv   = s1_v_q && s2_free;
	assign s2_adv   = s2_v_q && out_free;

	assign tick.ready = s1_free;

	assign tick_item.ch1_update = tick.ch1_update;
	assign tick_item.ch1_count  = tick.ch1_count;
	assign tick_item.ch2_update = tick.ch2_update;
	assign tick_item.ch2_count  = tick.ch2_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_free) s1_v_q <= tick.valid;
			if (s2_free) s2_v_q <= s1_v_q;
			if (out_free) out_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && s1_free) s1_q <= tick_item;
		if (s1_adv) s2_q <= mid;
		if (s2_adv) out_q <= res;
	end

	// Front end: takes in the counts, keeps the sticky enable, runs the watchdog and forms
	// the gain product. Its state moves on as the tick leaves the input register.
	fms_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (s1_adv),
		.item    (s1_q),
		.mid     (mid)
	);

	// Sequencer: finishes the motor command with hysteresis and steps the mode machine.
	fms_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (s2_adv),
		.mid     (s2_q),
		.res     (res)
	);

	assign result.valid         = out_v_q;
	assign result.fold_pulse    = out_q.fold_pulse;
	assign result.motor_pulse   = out_q.motor_pulse;
	assign result.drive_enable  = out_q.drive_enable;
	assign result.sequence_mode = out_q.sequence_mode;
	assign result.link_lost     = out_q.link_lost;
	assign result.motor_command = out_q.motor_command;

`ifndef SYNTHESIS
	// An empty input register must always be able to take a request.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v_q |-> tick.ready)
		else $error("input register empty but request refused");

	// A result showing the drive enabled may not be directly followed by a valid result showing it disabled.
	a_enable_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drive_enable) |=> !(result.valid && !result.drive_enable))
		else $error("drive enable dropped after being set");

	// A product held while the output is blocked must not be lost.
	a_mid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && !out_free) |=> s2_v_q)
		else $error("product register emptied while stalled");
`endif

endmodule

FILE: rtl/core/fms_front.sv
module fms_front
	import fms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  advance,
	input  item_t item,
	output mid_t  mid
);

	logic [15:0] held_ch1_q, held_ch2_q;
	logic        seen_ch1_q, seen_ch2_q;
	logic        restart_q;
	logic [8:0]  watch_ticks_q;
	logic        enabled_q;

	logic [15:0] h1, h2, h1_fin, h2_fin;
	logic        seen1, seen2, seen1_n, seen2_n;
	logic        in_window, enabled_n;
	logic [8:0]  ticks_inc, ticks_n;
	logic        restart_n, lost;

	always_comb begin
		h1    = item.ch1_update ? item.ch1_count : held_ch1_q;
		h2    = item.ch2_update ? item.ch2_count : held_ch2_q;
		seen1 = seen_ch1_q | item.ch1_update;
		seen2 = seen_ch2_q | item.ch2_update;

		// The window is tested before any fail count is substituted.
		in_window = (h1 > VALID_LOW) && (h2 > VALID_LOW) &&
			(h1 < VALID_HIGH) && (h2 < VALID_HIGH);
		enabled_n = enabled_q | in_window;

		ticks_inc = watch_ticks_q + 9'd1;
		ticks_n   = watch_ticks_q;
		restart_n = restart_q;
		seen1_n   = seen1;
		seen2_n   = seen2;
		h1_fin    = h1;
		h2_fin    = h2;
		lost      = 1'b0;

		if (restart_q) begin
			ticks_n   = '0;
			restart_n = 1'b0;
		end else begin
			ticks_n = ticks_inc;
			if (seen1 && seen2) begin
				seen1_n   = 1'b0;
				seen2_n   = 1'b0;
				restart_n = 1'b1;
			end else if (ticks_inc >= WATCH_LIMIT) begin
				h1_fin    = cfg.fail_count;
				h2_fin    = cfg.fail_count;
				lost      = 1'b1;
				restart_n = 1'b1;
			end
		end

		mid.held_ch1 = h1_fin;
		mid.product  = 33'(cfg.motor_gain) * 33'($signed({1'b0, h2_fin}));
		mid.enabled  = enabled_n;
		mid.lost     = lost;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ch1_q    <= '0;
			held_ch2_q    <= '0;
			seen_ch1_q    <= 1'b0;
			seen_ch2_q    <= 1'b0;
			restart_q     <= 1'b1;
			watch_ticks_q <= '0;
			enabled_q     <= 1'b0;
		end else if (advance) begin
			held_ch1_q    <= h1_fin;
			held_ch2_q    <= h2_fin;
			seen_ch1_q    <= seen1_n;
			seen_ch2_q    <= seen2_n;
			restart_q     <= restart_n;
			watch_ticks_q <= ticks_n;
			enabled_q     <= enabled_n;
		end
	end

endmodule

FILE: rtl/core/fms_seq.sv
module fms_seq
	import fms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic advance,
	input  mid_t mid,
	output res_t res
);

	logic [7:0]  last_cmd_q;
	mode_t       mode_q;
	logic [15:0] fold_q;
	logic [7:0]  motor_q;
	logic [4:0]  ramp_q;

	logic signed [34:0] sum;
	logic [7:0]  cmd_raw, cmd;
	mode_t       mode_n;
	logic [15:0] fold_n, fold_inc, fold_dec;
	logic [7:0]  motor_n, motor_inc, motor_dec;
	logic [4:0]  ramp_n, ramp_inc;
	logic        ramp_hit;
	logic [15:0] h1;

	always_comb begin
		sum = 35'(mid.product) + 35'(cfg.motor_offset) + 35'(ROUND_HALF);
		if (sum[34]) begin
			cmd_raw = '0;
		end else if (|sum[33:20]) begin
			cmd_raw = CMD_MAX;
		end else begin
			cmd_raw = sum[19:12];
		end

		// A drop of exactly one step is ignored.
		if ((last_cmd_q != 8'd0) && (cmd_raw == last_cmd_q - 8'd1)) begin
			cmd = last_cmd_q;
		end else begin
			cmd = cmd_raw;
		end

		h1        = mid.held_ch1;
		fold_inc  = fold_q + 16'd1;
		fold_dec  = fold_q - 16'd1;
		motor_inc = motor_q + 8'd1;
		motor_dec = motor_q - 8'd1;
		ramp_inc  = ramp_q + 5'd1;
		ramp_hit  = ramp_inc >= RAMP_DIVIDE;

		mode_n  = mode_q;
		fold_n  = fold_q;
		motor_n = motor_q;
		ramp_n  = ramp_q;

		case (mode_q)
			MODE_OFF: begin
				fold_n  = cfg.servo1_min;
				motor_n = cfg.servo2_min;
				if (h1 >= cfg.fold_threshold) mode_n = MODE_FOLD_OUT;
			end
			MODE_FOLD_OUT: begin
				motor_n = cfg.servo2_min;
				fold_n  = fold_inc;
				if (fold_inc >= cfg.servo1_max) mode_n = MODE_OUT;
				if (h1 < cfg.fold_threshold) mode_n = MODE_FOLD_IN;
			end
			MODE_OUT: begin
				motor_n = cfg.servo2_min;
				fold_n  = cfg.servo1_max;
				if (h1 < cfg.fold_threshold) mode_n = MODE_FOLD_IN;
				if (h1 > cfg.motor_threshold) mode_n = MODE_RAMP_UP;
			end
			MODE_RAMP_UP: begin
				fold_n = cfg.servo1_max;
				ramp_n = ramp_inc;
				if (ramp_hit) begin
					ramp_n  = '0;
					motor_n = motor_inc;
					if (motor_inc >= cmd) mode_n = MODE_ON;
				end
				if (h1 < cfg.motor_threshold) mode_n = MODE_OUT;
			end
			MODE_ON: begin
				fold_n  = cfg.servo1_max;
				motor_n = cmd;
				if (h1 < cfg.motor_threshold) mode_n = MODE_RAMP_DOWN;
			end
			MODE_RAMP_DOWN: begin
				fold_n = cfg.servo1_max;
				ramp_n = ramp_inc;
				if (ramp_hit) begin
					ramp_n  = '0;
					motor_n = motor_dec;
					if (motor_dec <= cfg.servo2_min) mode_n = MODE_FOLD_IN;
				end
				if (h1 > cfg.motor_threshold) mode_n = MODE_RAMP_UP;
			end
			MODE_FOLD_IN: begin
				motor_n = cfg.servo2_min;
				fold_n  = fold_dec;
				if (fold_dec <= cfg.servo1_min) mode_n = MODE_OFF;
				if (h1 > cfg.fold_threshold) mode_n = MODE_FOLD_OUT;
			end
			default: begin
				mode_n = MODE_OFF;
			end
		endcase

		res.fold_pulse    = fold_n;
		res.motor_pulse   = motor_n;
		res.drive_enable  = mid.enabled;
		res.sequence_mode = mode_code(mode_n);
		res.link_lost     = mid.lost;
		res.motor_command = cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= '0;
			mode_q     <= MODE_OFF;
			fold_q     <= '0;
			motor_q    <= '0;
			ramp_q     <= '0;
		end else if (advance) begin
			last_cmd_q <= cmd;
			mode_q     <= mode_n;
			fold_q     <= fold_n;
			motor_q    <= motor_n;
			ramp_q     <= ramp_n;
		end
	end

endmodule
